FILE: hw/rtl/dbs_pkg.sv
// Shared types and constants for the depth background subtraction block.
package dbs_pkg;

	localparam int IDX_W      = 15;
	localparam int DIST_W     = 16;
	localparam int LF_W       = 7;
	localparam int THR_W      = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LEARN_FRAMES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 1'd1;

	localparam logic [LF_W-1:0]  LEARN_FRAMES_RESET = 7'd50;
	localparam logic [THR_W-1:0] THRESHOLD_RESET    = 8'd32;

	typedef struct packed {
		logic [IDX_W-1:0]  pixel_index;
		logic [DIST_W-1:0] distance;
		logic              sample_valid;
		logic              frame_end;
	} pixel_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance_out;
		logic              keep_valid;
		logic              is_background;
		logic              learning;
	} result_t;

	// Status returned by the band test unit.
	typedef struct packed {
		logic done;
		logic bg;
	} band_res_t;

endpackage

FILE: hw/rtl/depth_background_subtract_top.sv
// Depth background subtraction top level.
// Each depth pixel beat is handled one at a time: the pixel's statistics word
// is read from an on-chip registered-read memory, then either updated and
// written back while learning, or run through a five-stage band test after
// learning. An item goes through the idle, read and output states while
// learning, and also after learning when the pixel is invalid or its index is
// out of range; a valid in-range pixel also waits in the calc state for the
// band test, between the read and output states, once learning is over. An
// item stays longer in its output state while the output register still holds a
// result beat that the consumer has not taken; a new pixel is taken while the
// previous result beat still waits in the output register. The statistics
// memory has no clearing pass: the first learning frame after reset or after
// any configuration write overwrites each pixel's entry, so every pixel index
// should appear in that frame. Pixels with an index at or beyond PIXEL_COUNT
// pass through untouched and are never marked background.
module depth_background_subtract_top #(
	parameter int PIXEL_COUNT      = 19200,
	parameter int MAX_LEARN_FRAMES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dbs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           pixel_valid,
	output logic                           pixel_ready,
	input  dbs_pkg::pixel_t                pixel,
	output logic                           result_valid,
	input  logic                           result_ready,
	output dbs_pkg::result_t               result
);

	import dbs_pkg::*;

	// Storage widths follow from the frame size and the longest learning run.
	localparam int ADDR_W  = $clog2(PIXEL_COUNT);
	localparam int CNT_W   = $clog2(MAX_LEARN_FRAMES + 1);
	localparam int SUM_W   = $clog2(longint'(MAX_LEARN_FRAMES) * 64'd65535 + 64'd1);
	localparam int SQ_W    = $clog2(longint'(MAX_LEARN_FRAMES) * 64'd4294836225 + 64'd1);
	localparam int ENTRY_W = CNT_W + SUM_W + SQ_W;
	localparam int LW      = (CNT_W > LF_W) ? CNT_W : LF_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_CALC = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t st_q, st_nxt;

	// Configuration and learning progress.
	logic [LF_W-1:0]  learn_frames_q;
	logic [THR_W-1:0] threshold_q;
	logic [LW-1:0]    frames_learned_q;
	logic [LW-1:0]    lf_ext, eff_learn;
	logic             learning_now;

	// The item in flight.
	logic [ADDR_W-1:0] addr_q;
	logic [DIST_W-1:0] dist_q;
	logic [31:0]       dsq_q;
	logic              valid_q, idx_ok_q, learn_q, first_q, bg_q;

	logic accept, idx_ok, band_start, load;

	// Statistics memory ports.
	logic [ENTRY_W-1:0] rd_data, wr_data;
	logic               wr_en;
	logic [CNT_W-1:0]   rd_cnt;
	logic [SUM_W-1:0]   rd_sum;
	logic [SQ_W-1:0]    rd_sq;

	band_res_t band_res;
	result_t   result_q;
	logic      result_valid_q;

	assign pixel_ready = (st_q == ST_IDLE);
	assign accept      = pixel_valid && pixel_ready;
	assign idx_ok      = 32'(pixel.pixel_index) < 32'(PIXEL_COUNT);

	// Learning length clamped into 1..MAX_LEARN_FRAMES.
	assign lf_ext    = LW'(learn_frames_q);
	assign eff_learn = (lf_ext == '0) ? LW'(1) :
	                   (lf_ext > LW'(MAX_LEARN_FRAMES)) ? LW'(MAX_LEARN_FRAMES) : lf_ext;
	assign learning_now = frames_learned_q < eff_learn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_frames_q   <= LEARN_FRAMES_RESET;
			threshold_q      <= THRESHOLD_RESET;
			frames_learned_q <= '0;
		end else if (cfg_we) begin
			// Every register write restarts learning from scratch.
			unique case (cfg_index)
				REG_LEARN_FRAMES: learn_frames_q <= cfg_data[LF_W-1:0];
				REG_THRESHOLD:    threshold_q    <= cfg_data[THR_W-1:0];
			endcase
			frames_learned_q <= '0;
		end else if (accept && learning_now && pixel.frame_end) begin
			frames_learned_q <= frames_learned_q + LW'(1);
		end
	end

	// Capture the accepted beat; the square of the distance is formed here so
	// the write-back in the read cycle only adds.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q   <= ADDR_W'(pixel.pixel_index);
			dist_q   <= pixel.distance;
			dsq_q    <= 32'(pixel.distance) * 32'(pixel.distance);
			valid_q  <= pixel.sample_valid;
			idx_ok_q <= idx_ok;
			learn_q  <= learning_now;
			first_q  <= (frames_learned_q == '0);
		end
		if (accept) begin
			bg_q <= 1'b0;
		end else if (st_q == ST_CALC && band_res.done) begin
			bg_q <= band_res.bg;
		end
	end

	dbs_mem #(
		.DEPTH  (PIXEL_COUNT),
		.ADDR_W (ADDR_W),
		.DATA_W (ENTRY_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (accept && idx_ok),
		.rd_addr (ADDR_W'(pixel.pixel_index)),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_q),
		.wr_data (wr_data)
	);

	assign {rd_cnt, rd_sum, rd_sq} = rd_data;

	// Read-modify-write while learning. The first learning frame overwrites
	// the entry with this sample alone (or clears it for an invalid sample);
	// later valid samples accumulate until the count saturates. Only one item
	// is in flight, so the write always lands before the next read.
	always_comb begin
		wr_en   = 1'b0;
		wr_data = '0;
		if (st_q == ST_READ && learn_q && idx_ok_q) begin
			if (first_q) begin
				wr_en = 1'b1;
				if (valid_q) begin
					wr_data = {CNT_W'(1), SUM_W'(dist_q), SQ_W'(dsq_q)};
				end
			end else if (valid_q && rd_cnt < CNT_W'(MAX_LEARN_FRAMES)) begin
				wr_en   = 1'b1;
				wr_data = {rd_cnt + CNT_W'(1), rd_sum + SUM_W'(dist_q),
				           rd_sq + SQ_W'(dsq_q)};
			end
		end
	end

	// After learning, only valid in-range pixels go through the band test.
	assign band_start = (st_q == ST_READ) && !learn_q && valid_q && idx_ok_q;

	dbs_band #(
		.CNT_W (CNT_W),
		.SUM_W (SUM_W),
		.SQ_W  (SQ_W)
	) u_band (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (band_start),
		.n      (rd_cnt),
		.s      (rd_sum),
		.q      (rd_sq),
		.d      (dist_q),
		.k      (threshold_q),
		.res    (band_res)
	);

	assign load = (st_q == ST_OUT) && (!result_valid_q || result_ready);

	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			ST_IDLE: if (accept) begin
				st_nxt = ST_READ;
			end
			ST_READ: st_nxt = band_start ? ST_CALC : ST_OUT;
			ST_CALC: if (band_res.done) begin
				st_nxt = ST_OUT;
			end
			ST_OUT: if (load) begin
				st_nxt = ST_IDLE;
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Output register: holds the result beat until the consumer takes it.
	always_ff @(posedge clk) begin
		if (load) begin
			result_q.distance_out  <= dist_q;
			result_q.keep_valid    <= valid_q && !bg_q;
			result_q.is_background <= bg_q;
			result_q.learning      <= learn_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: hw/rtl/dbs_mem.sv
// Single-port-write, registered-read statistics memory.
module dbs_mem #(
	parameter int DEPTH  = 19200,
	parameter int ADDR_W = 15,
	parameter int DATA_W = 67
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/dbs_band.sv
// Division-free background band test: (n*d - sum)^2 * 256 < k^2 * (n*sumsq - sum^2).
module dbs_band #(
	parameter int CNT_W = 7,
	parameter int SUM_W = 22,
	parameter int SQ_W  = 38
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [CNT_W-1:0]           n,
	input  logic [SUM_W-1:0]           s,
	input  logic [SQ_W-1:0]            q,
	input  logic [dbs_pkg::DIST_W-1:0] d,
	input  logic [dbs_pkg::THR_W-1:0]  k,
	output dbs_pkg::band_res_t         res
);

	import dbs_pkg::*;

	localparam int DIF_W = DIST_W + CNT_W;
	localparam int VAR_W = CNT_W + SQ_W;
	localparam int KK_W  = 2 * THR_W;
	localparam int LO_W  = (VAR_W + 1) / 2;
	localparam int HI_W  = VAR_W - LO_W;
	localparam int PLO_W = KK_W + LO_W;
	localparam int PHI_W = KK_W + HI_W;
	localparam int A2_W  = 2 * DIF_W;
	localparam int LHS_W = A2_W + 8;
	localparam int RHS_W = KK_W + VAR_W;
	localparam int CMP_W = ((LHS_W > RHS_W) ? LHS_W : RHS_W) + 1;

	logic [4:0] v_q;

	logic [DIF_W-1:0] dn_s1, sx_s1;
	logic [VAR_W-1:0] nq_s1, s2_s1;
	logic [KK_W-1:0]  kk_s1, kk_s2, kk_s3;
	logic             nz_s1;

	logic [DIF_W-1:0] adiff_s2;
	logic [VAR_W-1:0] var_s2;
	logic             pos_s2, pos_s3, pos_s4;

	logic [A2_W-1:0]  a2_s3, a2_s4;
	logic [PLO_W-1:0] plo_s3, plo_s4;
	logic [HI_W-1:0]  vhi_s3;
	logic [PHI_W-1:0] phi_s4;
	logic             bg_s5;

	logic [CMP_W-1:0] lhs, rhs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[3:0], start};
		end
	end

	always_ff @(posedge clk) begin
		// Stage 1: the independent products.
		dn_s1 <= DIF_W'(d) * DIF_W'(n);
		sx_s1 <= DIF_W'(s);
		nq_s1 <= VAR_W'(n) * VAR_W'(q);
		s2_s1 <= VAR_W'(s) * VAR_W'(s);
		kk_s1 <= KK_W'(k) * KK_W'(k);
		nz_s1 <= (n != '0);
		// Stage 2: absolute difference and scaled variance.
		adiff_s2 <= (dn_s1 >= sx_s1) ? (dn_s1 - sx_s1) : (sx_s1 - dn_s1);
		var_s2   <= nq_s1 - s2_s1;
		pos_s2   <= nz_s1 && (nq_s1 > s2_s1);
		kk_s2    <= kk_s1;
		// Stage 3: squared difference and low half of k^2 * var.
		a2_s3  <= A2_W'(adiff_s2) * A2_W'(adiff_s2);
		plo_s3 <= PLO_W'(kk_s2) * PLO_W'(var_s2[LO_W-1:0]);
		vhi_s3 <= var_s2[VAR_W-1 -: HI_W];
		kk_s3  <= kk_s2;
		pos_s3 <= pos_s2;
		// Stage 4: high half of k^2 * var.
		phi_s4 <= PHI_W'(kk_s3) * PHI_W'(vhi_s3);
		a2_s4  <= a2_s3;
		plo_s4 <= plo_s3;
		pos_s4 <= pos_s3;
		// Stage 5: recombine and compare.
		bg_s5 <= pos_s4 && (lhs < rhs);
	end

	assign lhs = CMP_W'(a2_s4) << 8;
	assign rhs = (CMP_W'(phi_s4) << LO_W) + CMP_W'(plo_s4);

	assign res.done = v_q[4];
	assign res.bg   = bg_s5;

endmodule
